>>> rtl/swipe_gesture_classifier_core_macros.svh
// Assertion macros shared by the swipe gesture classifier RTL.
`ifndef SWIPE_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define SWIPE_GESTURE_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sgc_pkg.sv
// Package with codes, widths and defaults of the swipe gesture classifier.
package sgc_pkg;

    // Default datapath widths.
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed widths of the configuration registers.
    localparam int MIN_DIST_W  = 12;
    localparam int MAX_DUR_W   = 16;
    localparam int RATIO_W     = 8;
    localparam int MODE_W      = 3;
    localparam int ACTION_W    = 3;
    localparam int KIND_W      = 2;
    localparam int MD_SQ_W     = 2 * MIN_DIST_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UI_MODE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LOCKED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_CHOICE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ON_SUBMIT_CARD = 3'd7;

    // Touch phases.
    localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd3;

    // Interaction modes.
    localparam logic [MODE_W-1:0] MODE_AMBIENT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPROVAL     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_USER_INPUT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRANSCRIPT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AWAITING_ACK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_APPLIED_GLOW = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ERROR_GLOW   = 3'd6;

    // Result actions.
    localparam logic [ACTION_W-1:0] ACT_BROWSE_PREV = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BROWSE_NEXT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPROVE     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DENY        = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SUBMIT      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DISCARD     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CANCEL      = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SELECT      = 3'd7;

    // Context latched when a contact starts and again when it ends.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              multi;
        logic              submit;
    } t_context;

endpackage

>>> rtl/swipe_gesture_classifier_core.sv
// Top level of the swipe gesture classifier: input register, one logic pass, result register.
//
// Touch events enter on the input channel (i_in_valid / o_in_stall) with a phase
// (down, move, up, cancel), a position and a millisecond timestamp. A transfer
// happens at a rising edge where i_in_valid is high and o_in_stall is low.
// Classified swipes leave on the output channel (o_out_valid / i_out_stall) as
// one action code; only an up event that ends a qualifying swipe produces one.
// Registers are written through a separate channel (i_cfg_valid / o_cfg_ready)
// that is always ready; write them only while no event is in flight.
//
// Throughput is one event per cycle while the receiver does not stall. After the
// input transfer the event sits in the input register while the contact update,
// deltas, squares, ratio products, compares and the action mapping settle, and
// the result register takes the outcome, which then shows on o_out_valid.
// When the receiver stalls, the result register holds its action and the
// input register can still take one event; o_in_stall rises only once both
// registers are full. Reset (synchronous, active low) empties both registers,
// drops any contact and returns the configuration to its defaults.
`include "swipe_gesture_classifier_core_macros.svh"

module swipe_gesture_classifier_core #(
    parameter int COORD_BITS = sgc_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = sgc_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Touch event channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sgc_pkg::KIND_W-1:0]     i_kind,
    input  logic [COORD_BITS-1:0]          i_pos_x,
    input  logic [COORD_BITS-1:0]          i_pos_y,
    input  logic [TIME_BITS-1:0]           i_time_ms,
    // Action channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sgc_pkg::ACTION_W-1:0]   o_action,
    // Register write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int PROD_W = COORD_BITS + sgc_pkg::RATIO_W;
    localparam int SUM_W  = (SQ_W + 1 > sgc_pkg::MD_SQ_W) ? SQ_W + 1 : sgc_pkg::MD_SQ_W;

    // Configuration registers.
    logic [sgc_pkg::MIN_DIST_W-1:0] r_min_distance;
    logic [sgc_pkg::MAX_DUR_W-1:0]  r_max_duration;
    logic [sgc_pkg::RATIO_W-1:0]    r_ratio_num;
    logic [sgc_pkg::RATIO_W-1:0]    r_ratio_den;
    logic [sgc_pkg::MODE_W-1:0]     r_ui_mode;
    logic                           r_input_locked;
    logic                           r_multi_choice;
    logic                           r_on_submit_card;

    // Zero in a numeric register acts as one.
    logic [sgc_pkg::MIN_DIST_W-1:0] min_dist_eff;
    logic [sgc_pkg::MAX_DUR_W-1:0]  max_dur_eff;
    logic [sgc_pkg::RATIO_W-1:0]    num_eff;
    logic [sgc_pkg::RATIO_W-1:0]    den_eff;
    sgc_pkg::t_context              cfg_ctx;

    // Contact state.
    logic                   r_tracking;
    logic [COORD_BITS-1:0]  r_start_x;
    logic [COORD_BITS-1:0]  r_start_y;
    logic [TIME_BITS-1:0]   r_start_time;
    sgc_pkg::t_context      r_contact;

    // Input register.
    logic                       r_in_v;
    logic [sgc_pkg::KIND_W-1:0] r_in_kind;
    logic [COORD_BITS-1:0]      r_in_x;
    logic [COORD_BITS-1:0]      r_in_y;
    logic [TIME_BITS-1:0]       r_in_t;

    // Result register.
    logic                           r_out_v;
    logic [sgc_pkg::ACTION_W-1:0]   r_action;

    // Handshake: the result register loads when empty or draining, the input
    // register when empty or when its event moves on.
    logic rdy_out;
    logic rdy_in;
    logic in_retire;

    // Single-pass datapath.
    logic                           swipe_right;
    logic                           swipe_up;
    logic [COORD_BITS-1:0]          ax;
    logic [COORD_BITS-1:0]          ay;
    logic [TIME_BITS-1:0]           elapsed;
    logic                           time_ok;
    logic [SQ_W-1:0]                sq_x;
    logic [SQ_W-1:0]                sq_y;
    logic [sgc_pkg::MD_SQ_W-1:0]    md_sq;
    logic [PROD_W-1:0]              ax_den;
    logic [PROD_W-1:0]              ay_num;
    logic [PROD_W-1:0]              ay_den;
    logic [PROD_W-1:0]              ax_num;
    logic                           dist_ok;
    logic                           horiz;
    logic                           vert;
    logic                           map_has;
    logic                           n_out_v;
    logic [sgc_pkg::ACTION_W-1:0]   n_action;

    assign rdy_out   = !r_out_v || !i_out_stall;
    assign rdy_in    = !r_in_v || rdy_out;
    assign in_retire = r_in_v && rdy_out;

    assign o_in_stall  = !rdy_in;
    assign o_out_valid = r_out_v;
    assign o_action    = r_action;
    assign o_cfg_ready = 1'b1;

    assign min_dist_eff = (r_min_distance == '0) ? sgc_pkg::MIN_DIST_W'(1) : r_min_distance;
    assign max_dur_eff  = (r_max_duration == '0) ? sgc_pkg::MAX_DUR_W'(1) : r_max_duration;
    assign num_eff      = (r_ratio_num == '0) ? sgc_pkg::RATIO_W'(1) : r_ratio_num;
    assign den_eff      = (r_ratio_den == '0) ? sgc_pkg::RATIO_W'(1) : r_ratio_den;

    assign cfg_ctx.mode   = r_ui_mode;
    assign cfg_ctx.multi  = r_multi_choice;
    assign cfg_ctx.submit = r_on_submit_card;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_distance   <= sgc_pkg::MIN_DIST_W'(1);
            r_max_duration   <= sgc_pkg::MAX_DUR_W'(1);
            r_ratio_num      <= sgc_pkg::RATIO_W'(1);
            r_ratio_den      <= sgc_pkg::RATIO_W'(1);
            r_ui_mode        <= sgc_pkg::MODE_AMBIENT;
            r_input_locked   <= 1'b0;
            r_multi_choice   <= 1'b0;
            r_on_submit_card <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sgc_pkg::REG_MIN_DISTANCE: begin
                    r_min_distance <= i_cfg_data[sgc_pkg::MIN_DIST_W-1:0];
                end
                sgc_pkg::REG_MAX_DURATION: begin
                    r_max_duration <= i_cfg_data[sgc_pkg::MAX_DUR_W-1:0];
                end
                sgc_pkg::REG_RATIO_NUM: begin
                    r_ratio_num <= i_cfg_data[sgc_pkg::RATIO_W-1:0];
                end
                sgc_pkg::REG_RATIO_DEN: begin
                    r_ratio_den <= i_cfg_data[sgc_pkg::RATIO_W-1:0];
                end
                sgc_pkg::REG_UI_MODE: begin
                    r_ui_mode <= i_cfg_data[sgc_pkg::MODE_W-1:0];
                end
                sgc_pkg::REG_INPUT_LOCKED: begin
                    r_input_locked <= i_cfg_data[0];
                end
                sgc_pkg::REG_MULTI_CHOICE: begin
                    r_multi_choice <= i_cfg_data[0];
                end
                sgc_pkg::REG_ON_SUBMIT_CARD: begin
                    r_on_submit_card <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: holds the accepted event while the result side is busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (rdy_in) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_in) begin
            r_in_kind <= i_kind;
            r_in_x    <= i_pos_x;
            r_in_y    <= i_pos_y;
            r_in_t    <= i_time_ms;
        end
    end

    // One pass from the input register to the result register. The event is
    // judged against the contact state before its own update, so a down event
    // followed directly by an up event sees the new start point.
    always_comb begin
        swipe_right = r_in_x > r_start_x;
        swipe_up    = r_in_y < r_start_y;
        ax          = swipe_right ? r_in_x - r_start_x : r_start_x - r_in_x;
        ay          = swipe_up ? r_start_y - r_in_y : r_in_y - r_start_y;
        elapsed     = r_in_t - r_start_time;
        time_ok     = (r_in_t >= r_start_time) && (elapsed <= TIME_BITS'(max_dur_eff));

        // The squares and ratio products are independent of each other.
        sq_x   = SQ_W'(ax) * SQ_W'(ax);
        sq_y   = SQ_W'(ay) * SQ_W'(ay);
        md_sq  = sgc_pkg::MD_SQ_W'(min_dist_eff) * sgc_pkg::MD_SQ_W'(min_dist_eff);
        ax_den = PROD_W'(ax) * PROD_W'(den_eff);
        ay_num = PROD_W'(ay) * PROD_W'(num_eff);
        ay_den = PROD_W'(ay) * PROD_W'(den_eff);
        ax_num = PROD_W'(ax) * PROD_W'(num_eff);

        dist_ok = (SUM_W'(sq_x) + SUM_W'(sq_y)) >= SUM_W'(md_sq);
        horiz   = ax_den >= ay_num;
        vert    = ay_den >= ax_num;

        // The horizontal axis is tested first; a horizontal swipe in a mode with
        // no side action gives nothing even if the vertical test would pass.
        map_has  = 1'b0;
        n_action = sgc_pkg::ACT_BROWSE_PREV;
        if (horiz) begin
            unique case (r_contact.mode)
                sgc_pkg::MODE_AMBIENT, sgc_pkg::MODE_USER_INPUT: begin
                    map_has  = 1'b1;
                    n_action = swipe_right ? sgc_pkg::ACT_BROWSE_NEXT : sgc_pkg::ACT_BROWSE_PREV;
                end
                sgc_pkg::MODE_APPROVAL: begin
                    map_has  = 1'b1;
                    n_action = swipe_right ? sgc_pkg::ACT_APPROVE : sgc_pkg::ACT_DENY;
                end
                sgc_pkg::MODE_TRANSCRIPT: begin
                    map_has  = 1'b1;
                    n_action = swipe_right ? sgc_pkg::ACT_SUBMIT : sgc_pkg::ACT_DISCARD;
                end
                default: begin
                end
            endcase
        end else if (vert) begin
            if (swipe_up) begin
                if (r_contact.mode == sgc_pkg::MODE_USER_INPUT) begin
                    map_has  = 1'b1;
                    n_action = (r_contact.multi && !r_contact.submit) ?
                               sgc_pkg::ACT_SELECT : sgc_pkg::ACT_SUBMIT;
                end
            end else if ((r_contact.mode == sgc_pkg::MODE_APPROVAL) ||
                         (r_contact.mode == sgc_pkg::MODE_USER_INPUT) ||
                         (r_contact.mode == sgc_pkg::MODE_TRANSCRIPT)) begin
                map_has  = 1'b1;
                n_action = sgc_pkg::ACT_CANCEL;
            end
        end

        n_out_v = r_in_v && (r_in_kind == sgc_pkg::KIND_UP) && r_tracking &&
                  time_ok && dist_ok && map_has;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_contact  <= '0;
        end else if (in_retire) begin
            unique case (r_in_kind)
                sgc_pkg::KIND_DOWN: begin
                    r_tracking <= !r_input_locked;
                    r_contact  <= cfg_ctx;
                end
                sgc_pkg::KIND_MOVE: begin
                end
                sgc_pkg::KIND_UP, sgc_pkg::KIND_CANCEL: begin
                    r_tracking <= 1'b0;
                    r_contact  <= cfg_ctx;
                end
                default: begin
                end
            endcase
        end
    end

    // Start point only matters while tracking, which only an unlocked down event sets.
    always_ff @(posedge i_clk) begin
        if (in_retire && (r_in_kind == sgc_pkg::KIND_DOWN)) begin
            r_start_x    <= r_in_x;
            r_start_y    <= r_in_y;
            r_start_time <= r_in_t;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (rdy_out) begin
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_action <= n_action;
        end
    end

    // The input side stalls only when both registers hold an event.
    `SGC_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
                    r_in_v && r_out_v, "input stalled with a free register")

    // An up event always ends the contact.
    `SGC_ASSERT_NEXT(a_up_drops_contact, i_clk, i_rst_n,
                     in_retire && (r_in_kind == sgc_pkg::KIND_UP), !r_tracking,
                     "tracking survived an up event")

    // An unlocked down event starts tracking at its own position.
    `SGC_ASSERT_NEXT(a_down_starts_contact, i_clk, i_rst_n,
                     in_retire && (r_in_kind == sgc_pkg::KIND_DOWN) && !r_input_locked,
                     r_tracking && (r_start_x == $past(r_in_x)) && (r_start_y == $past(r_in_y)),
                     "down event did not start a contact")

endmodule
